// File: src/mfp_pkg.sv
// Shared types and constants for the management frame parser.
package mfp_pkg;

    localparam int unsigned CountW = 17;
    localparam logic [CountW-1:0] COUNT_MAX = 17'h1FFFF;

    localparam int unsigned HDR_BYTES   = 6;
    localparam int unsigned SUBTYPE_POS = 8;
    localparam int unsigned ADDR_POS    = 12;
    localparam int unsigned ADDR_NUM    = 3;
    localparam int unsigned ADDR_BYTES  = 6;
    localparam int unsigned BODY_POS    = 32;
    localparam int unsigned BODY_NUM    = 3;

    localparam logic [CountW-1:0] EVT_HDR    = 17'd8;
    localparam logic [CountW-1:0] MIN_EVENT  = 17'd32;
    localparam logic [15:0]       FRM_HDR    = 16'd24;
    localparam logic [15:0]       MIN_AUTH    = 16'd30;
    localparam logic [15:0]       MIN_ASSOC   = 16'd28;
    localparam logic [15:0]       MIN_REASSOC = 16'd34;
    localparam logic [15:0]       MIN_REASON  = 16'd26;

    localparam logic [7:0] SUBTYPE_MASK = 8'hFC;
    localparam logic [7:0] ST_ASSOC     = 8'h00;
    localparam logic [7:0] ST_REASSOC   = 8'h20;
    localparam logic [7:0] ST_PROBE     = 8'h40;
    localparam logic [7:0] ST_DISASSOC  = 8'hA0;
    localparam logic [7:0] ST_AUTH      = 8'hB0;
    localparam logic [7:0] ST_DEAUTH    = 8'hC0;
    localparam logic [7:0] ST_ACTION    = 8'hD0;

    typedef enum logic [1:0] {
        OUT_OK          = 2'd0,
        OUT_BAD_HEADER  = 2'd1,
        OUT_BAD_LENGTH  = 2'd2,
        OUT_BAD_SUBTYPE = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        KIND_AUTH     = 3'd0,
        KIND_ASSOC    = 3'd1,
        KIND_REASSOC  = 3'd2,
        KIND_PROBE    = 3'd3,
        KIND_DEAUTH   = 3'd4,
        KIND_DISASSOC = 3'd5,
        KIND_ACTION   = 3'd6
    } t_kind;

    // Event state with the current byte already merged in.
    typedef struct packed {
        logic [CountW-1:0]          count;
        logic [47:0]                hdr;
        logic [7:0]                 sub;
        logic [ADDR_NUM-1:0][47:0]  addr;
        logic [BODY_NUM-1:0][15:0]  body;
    } t_frame_view;

endpackage

// File: src/mfp_capture.sv
// Byte counter and field capture registers for one event.
module mfp_capture (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output mfp_pkg::t_frame_view o_view
);

    logic [mfp_pkg::CountW-1:0]            r_count;
    logic [47:0]                           r_hdr;
    logic [7:0]                            r_sub;
    logic [mfp_pkg::ADDR_NUM-1:0][47:0]    r_addr;
    logic [mfp_pkg::BODY_NUM-1:0][15:0]    r_body;

    mfp_pkg::t_frame_view n_view;

    always_comb begin
        n_view.count = (r_count == mfp_pkg::COUNT_MAX) ? r_count
                                                       : r_count + 17'd1;
        n_view.hdr  = r_hdr;
        n_view.sub  = r_sub;
        n_view.addr = r_addr;
        n_view.body = r_body;
        for (int j = 0; j < mfp_pkg::HDR_BYTES; j++) begin
            if (r_count == 17'(j)) begin
                n_view.hdr[j*8 +: 8] = i_byte;
            end
        end
        if (r_count == 17'(mfp_pkg::SUBTYPE_POS)) begin
            n_view.sub = i_byte;
        end
        for (int k = 0; k < mfp_pkg::ADDR_NUM; k++) begin
            for (int m = 0; m < mfp_pkg::ADDR_BYTES; m++) begin
                if (r_count == 17'(mfp_pkg::ADDR_POS + k*mfp_pkg::ADDR_BYTES + m)) begin
                    n_view.addr[k][(mfp_pkg::ADDR_BYTES-1-m)*8 +: 8] = i_byte;
                end
            end
        end
        for (int k = 0; k < mfp_pkg::BODY_NUM; k++) begin
            for (int m = 0; m < 2; m++) begin
                if (r_count == 17'(mfp_pkg::BODY_POS + k*2 + m)) begin
                    n_view.body[k][m*8 +: 8] = i_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hdr   <= '0;
            r_sub   <= '0;
            r_addr  <= '0;
            r_body  <= '0;
        end else if (i_advance) begin
            if (i_last) begin
                r_count <= '0;
                r_hdr   <= '0;
                r_sub   <= '0;
                r_addr  <= '0;
                r_body  <= '0;
            end else begin
                r_count <= n_view.count;
                r_hdr   <= n_view.hdr;
                r_sub   <= n_view.sub;
                r_addr  <= n_view.addr;
                r_body  <= n_view.body;
            end
        end
    end

    assign o_view = n_view;

endmodule

// File: src/mgmt_frame_parser_top.sv
// Management frame parser top level: input register, classify, result register.
//
// Input channel: one event byte per transaction (i_data_byte, i_last flags the
// final byte), handshake i_in_valid / o_in_stall. Output channel: one result
// per event, handshake o_out_valid / i_out_stall, carrying the outcome, the
// frame kind and the captured header, address and body fields (all zero but
// the outcome when the outcome is not ok).
// Throughput: one byte per cycle while the input is not stalled. A byte is
// held in the input register and is then counted and captured; a final byte
// loads the result register at that edge, and the result is presented from
// that register and can be taken at the following edge.
// Reset (synchronous, active low) empties both registers and clears the
// byte count and captured fields.
// A stalled result holds in the output register. Bytes that are not final
// keep flowing meanwhile; a final byte waits in the input register, and the
// input stalls only while that byte waits.
module mgmt_frame_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_outcome,
    output logic [2:0]         o_frame_kind,
    output logic [7:0]         o_channel,
    output logic               o_band,
    output logic signed [15:0] o_signal_dbm,
    output logic [47:0]        o_destination,
    output logic [47:0]        o_source,
    output logic [47:0]        o_bssid,
    output logic [15:0]        o_frame_length,
    output logic [15:0]        o_word_a,
    output logic [15:0]        o_word_b,
    output logic [15:0]        o_word_c
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    logic       w_advance;
    logic       w_out_blocked;

    mfp_pkg::t_frame_view w_view;

    assign w_out_blocked = r_out_valid && i_out_stall;
    assign w_advance     = r_in_valid && !(r_in_last && w_out_blocked);
    assign o_in_stall    = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    mfp_capture u_capture (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_view    (w_view)
    );

    logic [7:0]        w_chan;
    logic [7:0]        w_bandb;
    logic [15:0]       w_flen;
    logic [7:0]        w_sub;
    logic [15:0]       w_need;
    logic [15:0]       w_wa;
    logic [15:0]       w_wb;
    logic [15:0]       w_wc;
    logic              w_known;
    mfp_pkg::t_kind    w_kind;
    mfp_pkg::t_outcome w_outcome;

    assign w_chan  = w_view.hdr[7:0];
    assign w_bandb = w_view.hdr[15:8];
    assign w_flen  = w_view.hdr[47:32];
    assign w_sub   = w_view.sub & mfp_pkg::SUBTYPE_MASK;

    always_comb begin
        w_known = 1'b1;
        w_kind  = mfp_pkg::KIND_AUTH;
        w_need  = '0;
        w_wa    = '0;
        w_wb    = '0;
        w_wc    = '0;
        case (w_sub)
            mfp_pkg::ST_AUTH: begin
                w_kind = mfp_pkg::KIND_AUTH;
                w_need = mfp_pkg::MIN_AUTH;
                w_wa   = w_view.body[0];
                w_wb   = w_view.body[1];
                w_wc   = w_view.body[2];
            end
            mfp_pkg::ST_ASSOC: begin
                w_kind = mfp_pkg::KIND_ASSOC;
                w_need = mfp_pkg::MIN_ASSOC;
                w_wa   = w_view.body[0];
                w_wb   = w_view.body[1];
            end
            mfp_pkg::ST_REASSOC: begin
                w_kind = mfp_pkg::KIND_REASSOC;
                w_need = mfp_pkg::MIN_REASSOC;
                w_wa   = w_view.body[0];
                w_wb   = w_view.body[1];
            end
            mfp_pkg::ST_PROBE: begin
                w_kind = mfp_pkg::KIND_PROBE;
            end
            mfp_pkg::ST_DEAUTH: begin
                w_kind = mfp_pkg::KIND_DEAUTH;
                w_need = mfp_pkg::MIN_REASON;
                w_wa   = w_view.body[0];
            end
            mfp_pkg::ST_DISASSOC: begin
                w_kind = mfp_pkg::KIND_DISASSOC;
                w_need = mfp_pkg::MIN_REASON;
                w_wa   = w_view.body[0];
            end
            mfp_pkg::ST_ACTION: begin
                w_kind = mfp_pkg::KIND_ACTION;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (w_view.count < mfp_pkg::MIN_EVENT || w_chan == 8'd0 || w_bandb > 8'd1) begin
            w_outcome = mfp_pkg::OUT_BAD_HEADER;
        end else if (w_flen < mfp_pkg::FRM_HDR
                     || ({1'b0, w_flen} + mfp_pkg::EVT_HDR) > w_view.count) begin
            w_outcome = mfp_pkg::OUT_BAD_LENGTH;
        end else if (!w_known) begin
            w_outcome = mfp_pkg::OUT_BAD_SUBTYPE;
        end else if (w_flen < w_need) begin
            w_outcome = mfp_pkg::OUT_BAD_LENGTH;
        end else begin
            w_outcome = mfp_pkg::OUT_OK;
        end
    end

    logic w_load;
    logic w_ok;

    assign w_load = w_advance && r_in_last;
    assign w_ok   = (w_outcome == mfp_pkg::OUT_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_outcome      <= w_outcome;
            o_frame_kind   <= w_ok ? w_kind : 3'd0;
            o_channel      <= w_ok ? w_chan : 8'd0;
            o_band         <= w_ok && (w_bandb != 8'd0);
            o_signal_dbm   <= w_ok ? w_view.hdr[31:16] : 16'sd0;
            o_destination  <= w_ok ? w_view.addr[0] : 48'd0;
            o_source       <= w_ok ? w_view.addr[1] : 48'd0;
            o_bssid        <= w_ok ? w_view.addr[2] : 48'd0;
            o_frame_length <= w_ok ? w_flen : 16'd0;
            o_word_a       <= w_ok ? w_wa : 16'd0;
            o_word_b       <= w_ok ? w_wb : 16'd0;
            o_word_c       <= w_ok ? w_wc : 16'd0;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome != mfp_pkg::OUT_OK)
            |-> (o_frame_kind == 3'd0 && o_channel == 8'd0 && o_frame_length == 16'd0))
        else $error("failed outcome carries nonzero fields");

    a_stall_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && r_out_valid && i_out_stall))
        else $error("input stalled without a waiting final byte");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_in_valid && r_in_last))
        else $error("result without a final byte");

    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> (!r_out_valid && !r_in_valid))
        else $error("registers not empty after reset");
`endif

endmodule

// File: verif/mgmt_frame_parser_top_tb.sv
// Self-checking testbench for mgmt_frame_parser_top: directed and random events.
`timescale 1ns / 1ps

module mgmt_frame_parser_top_tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stim_byte;

    typedef struct packed {
        mfp_pkg::t_outcome outcome;
        mfp_pkg::t_kind    kind;
        logic [7:0]        channel;
        logic              band;
        logic [15:0]       sig_dbm;
        logic [47:0]       dst;
        logic [47:0]       src;
        logic [47:0]       bssid;
        logic [15:0]       flen;
        logic [15:0]       wa;
        logic [15:0]       wb;
        logic [15:0]       wc;
    } t_parse_result;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } t_fill;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [7:0]         i_data_byte;
    logic               i_last;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_outcome;
    logic [2:0]         o_frame_kind;
    logic [7:0]         o_channel;
    logic               o_band;
    logic signed [15:0] o_signal_dbm;
    logic [47:0]        o_destination;
    logic [47:0]        o_source;
    logic [47:0]        o_bssid;
    logic [15:0]        o_frame_length;
    logic [15:0]        o_word_a;
    logic [15:0]        o_word_b;
    logic [15:0]        o_word_c;

    t_stim_byte    byte_queue[$];
    t_parse_result pending_results[$];
    t_parse_result got_res;
    t_parse_result exp_res;

    // predictor state
    logic [mfp_pkg::CountW-1:0] ev_count;
    logic [47:0]                ev_hdr;
    logic [7:0]                 ev_fc;
    logic [47:0]                ev_addr[mfp_pkg::ADDR_NUM];
    logic [15:0]                ev_body[mfp_pkg::BODY_NUM];

    bit in_taken;
    int mismatch_count;
    int bytes_queued;
    int burst_left;
    int gap_left;
    int stall_run;
    int stall_mode;

    mgmt_frame_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_outcome      (o_outcome),
        .o_frame_kind   (o_frame_kind),
        .o_channel      (o_channel),
        .o_band         (o_band),
        .o_signal_dbm   (o_signal_dbm),
        .o_destination  (o_destination),
        .o_source       (o_source),
        .o_bssid        (o_bssid),
        .o_frame_length (o_frame_length),
        .o_word_a       (o_word_a),
        .o_word_b       (o_word_b),
        .o_word_c       (o_word_c)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic clear_event();
        begin
            ev_count = '0;
            ev_hdr   = '0;
            ev_fc    = '0;
            for (int i = 0; i < mfp_pkg::ADDR_NUM; i++) ev_addr[i] = '0;
            for (int i = 0; i < mfp_pkg::BODY_NUM; i++) ev_body[i] = '0;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic lst);
        t_parse_result              r;
        mfp_pkg::t_outcome          oc;
        logic [mfp_pkg::CountW-1:0] plen;
        logic [7:0]                 chan;
        logic [7:0]                 bandb;
        logic [7:0]                 sub;
        logic [15:0]                flen;
        logic [15:0]                need;
        int                         pos;
        int                         k;
        int                         s;
        begin
            pos = int'(ev_count);
            if (pos < mfp_pkg::HDR_BYTES) begin
                ev_hdr[pos*8 +: 8] = b;
            end else if (pos == mfp_pkg::SUBTYPE_POS) begin
                ev_fc = b;
            end else if (pos >= mfp_pkg::ADDR_POS
                         && pos < mfp_pkg::ADDR_POS + mfp_pkg::ADDR_NUM * mfp_pkg::ADDR_BYTES)
            begin
                k = (pos - mfp_pkg::ADDR_POS) / mfp_pkg::ADDR_BYTES;
                s = mfp_pkg::ADDR_BYTES - 1 - (pos - mfp_pkg::ADDR_POS) % mfp_pkg::ADDR_BYTES;
                ev_addr[k][s*8 +: 8] = b;
            end else if (pos >= mfp_pkg::BODY_POS
                         && pos < mfp_pkg::BODY_POS + 2 * mfp_pkg::BODY_NUM) begin
                k = (pos - mfp_pkg::BODY_POS) / 2;
                s = (pos - mfp_pkg::BODY_POS) % 2;
                ev_body[k][s*8 +: 8] = b;
            end
            if (ev_count != mfp_pkg::COUNT_MAX) ev_count = ev_count + 1'b1;
            if (lst) begin
                r     = '0;
                need  = '0;
                plen  = ev_count;
                chan  = ev_hdr[7:0];
                bandb = ev_hdr[15:8];
                flen  = ev_hdr[47:32];
                sub   = ev_fc & mfp_pkg::SUBTYPE_MASK;
                r.outcome = mfp_pkg::OUT_OK;
                if (plen < mfp_pkg::MIN_EVENT || chan == 8'd0 || bandb > 8'd1) begin
                    r.outcome = mfp_pkg::OUT_BAD_HEADER;
                end else if (flen < mfp_pkg::FRM_HDR
                             || mfp_pkg::CountW'(flen) > plen - mfp_pkg::EVT_HDR) begin
                    r.outcome = mfp_pkg::OUT_BAD_LENGTH;
                end else begin
                    case (sub)
                        mfp_pkg::ST_AUTH: begin
                            r.kind = mfp_pkg::KIND_AUTH;
                            need   = mfp_pkg::MIN_AUTH;
                            r.wa   = ev_body[0];
                            r.wb   = ev_body[1];
                            r.wc   = ev_body[2];
                        end
                        mfp_pkg::ST_ASSOC: begin
                            r.kind = mfp_pkg::KIND_ASSOC;
                            need   = mfp_pkg::MIN_ASSOC;
                            r.wa   = ev_body[0];
                            r.wb   = ev_body[1];
                        end
                        mfp_pkg::ST_REASSOC: begin
                            r.kind = mfp_pkg::KIND_REASSOC;
                            need   = mfp_pkg::MIN_REASSOC;
                            r.wa   = ev_body[0];
                            r.wb   = ev_body[1];
                        end
                        mfp_pkg::ST_PROBE: r.kind = mfp_pkg::KIND_PROBE;
                        mfp_pkg::ST_DEAUTH: begin
                            r.kind = mfp_pkg::KIND_DEAUTH;
                            need   = mfp_pkg::MIN_REASON;
                            r.wa   = ev_body[0];
                        end
                        mfp_pkg::ST_DISASSOC: begin
                            r.kind = mfp_pkg::KIND_DISASSOC;
                            need   = mfp_pkg::MIN_REASON;
                            r.wa   = ev_body[0];
                        end
                        mfp_pkg::ST_ACTION: r.kind = mfp_pkg::KIND_ACTION;
                        default: r.outcome = mfp_pkg::OUT_BAD_SUBTYPE;
                    endcase
                    if (r.outcome == mfp_pkg::OUT_OK && flen < need)
                        r.outcome = mfp_pkg::OUT_BAD_LENGTH;
                end
                if (r.outcome == mfp_pkg::OUT_OK) begin
                    r.channel = chan;
                    r.band    = (bandb != 8'd0);
                    r.sig_dbm = ev_hdr[31:16];
                    r.dst     = ev_addr[0];
                    r.src     = ev_addr[1];
                    r.bssid   = ev_addr[2];
                    r.flen    = flen;
                end else begin
                    oc        = r.outcome;
                    r         = '0;
                    r.outcome = oc;
                end
                pending_results.push_back(r);
                clear_event();
            end
        end
    endtask

    function automatic string fmt_result(input t_parse_result r);
        return $sformatf(
            "oc=%0d kind=%0d ch=%h band=%b sig=%h dst=%h src=%h bss=%h len=%h %h %h %h",
            r.outcome, r.kind, r.channel, r.band, r.sig_dbm, r.dst, r.src, r.bssid,
            r.flen, r.wa, r.wb, r.wc);
    endfunction

    task automatic add_event(input logic [7:0] chan, input logic [7:0] bandb,
                             input logic [15:0] sig, input logic [15:0] flen,
                             input logic [7:0] fc, input int plen, input t_fill fill);
        logic [7:0] v;
        begin
            for (int i = 0; i < plen; i++) begin
                case (fill)
                    FILL_ONES:  v = 8'hFF;
                    FILL_ZEROS: v = 8'h00;
                    default:    v = 8'($urandom);
                endcase
                case (i)
                    0: v = chan;
                    1: v = bandb;
                    2: v = sig[7:0];
                    3: v = sig[15:8];
                    4: v = flen[7:0];
                    5: v = flen[15:8];
                    mfp_pkg::SUBTYPE_POS: v = fc;
                    default: ;
                endcase
                byte_queue.push_back('{data: v, last: (i == plen - 1)});
            end
            bytes_queued += plen;
        end
    endtask

    task automatic add_random_event();
        logic [7:0]  chan;
        logic [7:0]  bandb;
        logic [7:0]  fc;
        logic [15:0] sig;
        logic [15:0] flen;
        int          plen;
        int          sel;
        begin
            sel = $urandom_range(0, 99);
            sig = 16'($urandom);
            case ($urandom_range(0, 7))
                0: fc = mfp_pkg::ST_AUTH;
                1: fc = mfp_pkg::ST_ASSOC;
                2: fc = mfp_pkg::ST_REASSOC;
                3: fc = mfp_pkg::ST_PROBE;
                4: fc = mfp_pkg::ST_DEAUTH;
                5: fc = mfp_pkg::ST_DISASSOC;
                6: fc = mfp_pkg::ST_ACTION;
                default: fc = 8'($urandom);
            endcase
            fc = fc | 8'($urandom_range(0, 3));
            if (sel < 75) begin
                chan  = 8'($urandom_range(1, 255));
                bandb = 8'($urandom_range(0, 1));
                if ($urandom_range(0, 19) == 0) flen = 16'($urandom_range(49, 200));
                else flen = 16'($urandom_range(24, 48));
                plen = int'(flen) + 8;
                if ($urandom_range(0, 3) == 0) plen += $urandom_range(1, 6);
            end else if (sel < 90) begin
                chan  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
                bandb = 8'($urandom_range(0, 3));
                flen  = 16'($urandom_range(0, 60));
                plen  = $urandom_range(20, 70);
            end else begin
                chan  = 8'($urandom);
                bandb = 8'($urandom);
                flen  = 16'($urandom);
                plen  = $urandom_range(1, 80);
            end
            add_event(chan, bandb, sig, flen, fc, plen, FILL_RANDOM);
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        t_stim_byte item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (byte_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                item = byte_queue.pop_front();
                i_in_valid  <= 1'b1;
                i_data_byte <= item.data;
                i_last      <= item.last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: free runs, random stalls and solid stalls
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       stall_run = $urandom_range(1, 40);
                1:       stall_run = $urandom_range(1, 30);
                default: stall_run = $urandom_range(1, 20);
            endcase
        end
        stall_run--;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= 1'($urandom_range(0, 1));
            default: i_out_stall <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            // input transaction accepted at this edge
            in_taken = i_in_valid && !o_in_stall;
            if (in_taken) absorb_byte(i_data_byte, i_last);
            if (o_out_valid && !i_out_stall) begin
                got_res.outcome = mfp_pkg::t_outcome'(o_outcome);
                got_res.kind    = mfp_pkg::t_kind'(o_frame_kind);
                got_res.channel = o_channel;
                got_res.band    = o_band;
                got_res.sig_dbm = o_signal_dbm;
                got_res.dst     = o_destination;
                got_res.src     = o_source;
                got_res.bssid   = o_bssid;
                got_res.flen    = o_frame_length;
                got_res.wa      = o_word_a;
                got_res.wb      = o_word_b;
                got_res.wc      = o_word_c;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result: %s", fmt_result(got_res));
                end else begin
                    exp_res = pending_results.pop_front();
                    if (got_res !== exp_res) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch at %0t", $realtime);
                            $display("  exp %s", fmt_result(exp_res));
                            $display("  got %s", fmt_result(got_res));
                        end
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_data_byte    = 8'h00;
        i_last         = 1'b0;
        i_out_stall    = 1'b0;
        in_taken       = 1'b0;
        mismatch_count = 0;
        bytes_queued   = 0;
        burst_left     = 0;
        gap_left       = 0;
        stall_run      = 0;
        stall_mode     = 0;
        clear_event();

        // every kind at its minimum frame length, field extremes
        add_event(8'd1,   8'd0, 16'h7FFF, 16'd30, mfp_pkg::ST_AUTH,     38, FILL_RANDOM);
        add_event(8'd255, 8'd1, 16'h8000, 16'd28, mfp_pkg::ST_ASSOC,    36, FILL_ONES);
        add_event(8'd6,   8'd0, 16'hFFC4, 16'd34, mfp_pkg::ST_REASSOC,  42, FILL_ZEROS);
        add_event(8'd11,  8'd0, 16'hFFB0, 16'd24, mfp_pkg::ST_PROBE,    32, FILL_RANDOM);
        add_event(8'd36,  8'd1, 16'h0000, 16'd26, mfp_pkg::ST_DEAUTH,   34, FILL_RANDOM);
        add_event(8'd149, 8'd1, 16'hFFFF, 16'd26, mfp_pkg::ST_DISASSOC, 34, FILL_ONES);
        add_event(8'd3,   8'd0, 16'h1234, 16'd24, mfp_pkg::ST_ACTION | 8'h03, 32, FILL_RANDOM);
        add_event(8'd7,   8'd0, 16'hABCD, 16'd60, mfp_pkg::ST_AUTH | 8'h01, 68, FILL_RANDOM);
        // frame length just under each subtype minimum
        add_event(8'd1, 8'd0, 16'hFFA0, 16'd29, mfp_pkg::ST_AUTH,     37, FILL_RANDOM);
        add_event(8'd1, 8'd0, 16'hFFA0, 16'd27, mfp_pkg::ST_ASSOC,    35, FILL_RANDOM);
        add_event(8'd1, 8'd0, 16'hFFA0, 16'd33, mfp_pkg::ST_REASSOC,  41, FILL_RANDOM);
        add_event(8'd1, 8'd0, 16'hFFA0, 16'd25, mfp_pkg::ST_DEAUTH,   33, FILL_RANDOM);
        add_event(8'd1, 8'd0, 16'hFFA0, 16'd25, mfp_pkg::ST_DISASSOC, 33, FILL_RANDOM);
        // protocol length errors
        add_event(8'd1, 8'd0, 16'h0000, 16'd23, mfp_pkg::ST_PROBE, 40, FILL_RANDOM);
        add_event(8'd1, 8'd0, 16'h0000, 16'd40, mfp_pkg::ST_PROBE, 47, FILL_RANDOM);
        // invalid headers
        add_event(8'd1,  8'd0,   16'h0000, 16'd23, mfp_pkg::ST_PROBE, 31, FILL_RANDOM);
        add_event(8'd0,  8'd0,   16'h0000, 16'd24, mfp_pkg::ST_PROBE, 32, FILL_RANDOM);
        add_event(8'd1,  8'd2,   16'h0000, 16'd24, mfp_pkg::ST_PROBE, 32, FILL_RANDOM);
        add_event(8'd1,  8'd255, 16'h0000, 16'd24, mfp_pkg::ST_PROBE, 32, FILL_RANDOM);
        add_event(8'd1,  8'd0,   16'h0000, 16'd0,  mfp_pkg::ST_PROBE, 1,  FILL_RANDOM);
        // unknown subtypes
        add_event(8'd1, 8'd0, 16'h0000, 16'd24, 8'h80, 32, FILL_RANDOM);
        add_event(8'd1, 8'd0, 16'h0000, 16'd24, 8'hFC, 32, FILL_RANDOM);

        while (bytes_queued < 900) begin
            add_random_event();
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_queue.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: mgmt_frame_parser_top.f
src/mfp_pkg.sv
src/mfp_capture.sv
src/mgmt_frame_parser_top.sv
verif/mgmt_frame_parser_top_tb.sv
